// File: rtl/core/ptsched_pkg.sv
// Shared types and constants for the process table scheduler.
// Used by the controller, the datapath, the top level and the checker.
package ptsched_pkg;

   localparam int SLOTS_DEFAULT = 64;

   localparam logic [7:0]         WINDOW_RESET = 8'd20;
   localparam logic signed [31:0] NICE_HIGH    = 32'sd19;
   localparam logic signed [31:0] NICE_LOW     = -32'sd20;

   // command codes
   localparam logic [2:0] CMD_TICK = 3'd0;
   localparam logic [2:0] CMD_FORK = 3'd1;
   localparam logic [2:0] CMD_EXIT = 3'd2;
   localparam logic [2:0] CMD_WAIT = 3'd3;
   localparam logic [2:0] CMD_NICE = 3'd4;

   // result status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_FULL     = 2'd1;
   localparam logic [1:0] STS_NO_CHILD = 2'd2;
   localparam logic [1:0] STS_SLEEPING = 2'd3;

   // register indexes
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_WINDOW    = 1'b1;

   typedef enum logic [1:0] {
      SS_READY    = 2'd0,
      SS_RUNNING  = 2'd1,
      SS_SLEEPING = 2'd2,
      SS_ZOMBIE   = 2'd3
   } slot_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_LOAD,
      OP_LIVE_SCAN,
      OP_RD_CUR,
      OP_TICK_UPD,
      OP_FORK_SCAN,
      OP_FORK_WR,
      OP_EXIT_WR,
      OP_RD_PAR,
      OP_WAKE_WR,
      OP_WAIT_SCAN,
      OP_WAIT_ACT,
      OP_PEND_WR,
      OP_NICE_WR,
      OP_SW_PREP,
      OP_SW_SCAN,
      OP_SW_FIN,
      OP_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic slice_end;
      logic wake;
      logic zombie_found;
      logic ready_found;
      logic rsp_busy;
   } dp_sts_type;

endpackage

// File: rtl/core/ptsched_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ptsched_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ptsched_ctrl.sv
// Sequencer for the process table scheduler: steps each command through
// the datapath micro-operations. Depends on ptsched_pkg.
module ptsched_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [2:0]              req_command,
   input  ptsched_pkg::dp_sts_type sts,
   output ptsched_pkg::dp_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_LIVE, S_TICK_RD, S_TICK_UPD,
      S_FORK_SCAN, S_FORK_WR, S_EXIT_RD, S_EXIT_WR, S_PAR_RD, S_WAKE_WR,
      S_WAIT_SCAN, S_WAIT_ACT, S_PEND_RD, S_PEND_WR, S_NICE_RD, S_NICE_WR,
      S_SW_PREP, S_SW_SCAN, S_SW_FIN, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd.op   = ptsched_pkg::OP_NONE;
      unique case (state_ff)
         S_INIT: begin
            cmd.op   = ptsched_pkg::OP_INIT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.op = ptsched_pkg::OP_LOAD;
               unique case (req_command)
                  ptsched_pkg::CMD_TICK: state_in = S_LIVE;
                  ptsched_pkg::CMD_FORK: state_in = S_FORK_SCAN;
                  ptsched_pkg::CMD_EXIT: state_in = S_EXIT_RD;
                  ptsched_pkg::CMD_WAIT: state_in = S_WAIT_SCAN;
                  ptsched_pkg::CMD_NICE: state_in = S_NICE_RD;
                  default:               state_in = S_DONE;
               endcase
            end
         end
         S_LIVE: begin
            cmd.op = ptsched_pkg::OP_LIVE_SCAN;
            if (sts.scan_done) state_in = S_TICK_RD;
         end
         S_TICK_RD: begin
            cmd.op   = ptsched_pkg::OP_RD_CUR;
            state_in = S_TICK_UPD;
         end
         S_TICK_UPD: begin
            cmd.op   = ptsched_pkg::OP_TICK_UPD;
            state_in = sts.slice_end ? S_SW_PREP : S_DONE;
         end
         S_FORK_SCAN: begin
            cmd.op = ptsched_pkg::OP_FORK_SCAN;
            if (sts.scan_done) state_in = S_FORK_WR;
         end
         S_FORK_WR: begin
            cmd.op   = ptsched_pkg::OP_FORK_WR;
            state_in = S_DONE;
         end
         S_EXIT_RD: begin
            cmd.op   = ptsched_pkg::OP_RD_CUR;
            state_in = S_EXIT_WR;
         end
         S_EXIT_WR: begin
            cmd.op   = ptsched_pkg::OP_EXIT_WR;
            state_in = sts.wake ? S_PAR_RD : S_SW_PREP;
         end
         S_PAR_RD: begin
            cmd.op   = ptsched_pkg::OP_RD_PAR;
            state_in = S_WAKE_WR;
         end
         S_WAKE_WR: begin
            cmd.op   = ptsched_pkg::OP_WAKE_WR;
            state_in = S_SW_PREP;
         end
         S_WAIT_SCAN: begin
            cmd.op = ptsched_pkg::OP_WAIT_SCAN;
            if (sts.scan_done) state_in = S_WAIT_ACT;
         end
         S_WAIT_ACT: begin
            cmd.op = ptsched_pkg::OP_WAIT_ACT;
            priority if (sts.zombie_found) state_in = S_SW_PREP;
            else if (sts.ready_found)      state_in = S_PEND_RD;
            else                           state_in = S_DONE;
         end
         S_PEND_RD: begin
            cmd.op   = ptsched_pkg::OP_RD_CUR;
            state_in = S_PEND_WR;
         end
         S_PEND_WR: begin
            cmd.op   = ptsched_pkg::OP_PEND_WR;
            state_in = S_SW_PREP;
         end
         S_NICE_RD: begin
            cmd.op   = ptsched_pkg::OP_RD_CUR;
            state_in = S_NICE_WR;
         end
         S_NICE_WR: begin
            cmd.op   = ptsched_pkg::OP_NICE_WR;
            state_in = S_DONE;
         end
         S_SW_PREP: begin
            cmd.op   = ptsched_pkg::OP_SW_PREP;
            state_in = S_SW_SCAN;
         end
         S_SW_SCAN: begin
            cmd.op = ptsched_pkg::OP_SW_SCAN;
            if (sts.scan_done) state_in = S_SW_FIN;
         end
         S_SW_FIN: begin
            cmd.op   = ptsched_pkg::OP_SW_FIN;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.op   = ptsched_pkg::OP_DONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/ptsched_dp.sv
// Datapath: slot flags, per-slot record RAM, scan pipeline, counters and
// the result register. Depends on ptsched_pkg and ptsched_ram.
module ptsched_dp #(
   parameter int SLOTS = ptsched_pkg::SLOTS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ptsched_pkg::dp_cmd_type cmd,
   output ptsched_pkg::dp_sts_type sts,
   input  logic signed [31:0]      req_argument,
   input  logic                    csr_valid,
   input  logic                    csr_index,
   input  logic [31:0]             csr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_value,
   output logic [5:0]              rsp_running_slot,
   output logic                    rsp_switched,
   output logic [31:0]             rsp_tick_total
);

   localparam int PW  = $clog2(SLOTS);
   localparam int CW  = $clog2(SLOTS + 1);
   localparam int PRW = 33 + PW;

   typedef struct packed {
      logic [PW-1:0]     pend_slot;
      logic              pend_valid;
      logic [31:0]       held;
      logic [31:0]       slice;
      logic [31:0]       cpu;
      logic signed [5:0] nice;
      logic [PW-1:0]     parent;
   } word_type;

   localparam int WW = $bits(word_type);

   logic                        used_ff [SLOTS];
   logic                        used_in [SLOTS];
   ptsched_pkg::slot_state_type state_ff [SLOTS];
   ptsched_pkg::slot_state_type state_in [SLOTS];

   logic [PW-1:0]      cur_ff, cur_in;
   logic [31:0]        tick_ff, tick_in;
   logic signed [31:0] thresh_ff;
   logic [7:0]         window_ff;
   logic signed [31:0] arg_ff, arg_in;
   logic [PW-1:0]      live_ff, live_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               ev_ff, ev_in;
   logic [PW-1:0]      idx_d_ff, idx_d_in;
   logic               ffound_ff, ffound_in;
   logic [PW-1:0]      fslot_ff, fslot_in;
   logic               zfound_ff, zfound_in;
   logic [PW-1:0]      zslot_ff, zslot_in;
   logic [31:0]        zheld_ff, zheld_in;
   logic               rfound_ff, rfound_in;
   logic [PW-1:0]      rslot_ff, rslot_in;
   logic [PW-1:0]      par_ff, par_in;
   logic               was_run_ff, was_run_in;
   logic               pfound_ff, pfound_in;
   logic [PW-1:0]      pick_ff, pick_in;
   logic signed [33:0] best_ff, best_in;
   word_type           pword_ff, pword_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic [31:0]        res_value_ff, res_value_in;
   logic               res_sw_ff, res_sw_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff;
   logic [31:0]        rsp_value_ff;
   logic [5:0]         rsp_slot_ff;
   logic               rsp_sw_ff;
   logic [31:0]        rsp_tick_ff;

   logic [WW-1:0]      ram_rdata, ram_wdata;
   logic               ram_we;
   logic [PW-1:0]      ram_waddr, ram_raddr;
   word_type           rd_w, wr_w;

   logic [31:0]        cpu_new, slice_new;
   logic [32:0]        slice_inc;
   logic [PW-1:0]      live_eff;
   logic [PRW-1:0]     prod;
   logic               slice_end;
   logic signed [33:0] key;
   logic [PW-1:0]      p_slot, c_slot;
   logic               wake;
   logic               is_scan;

   ptsched_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_w      = word_type'(ram_rdata);
   assign ram_wdata = WW'(wr_w);

   // slice reaches floor(window/live) exactly when window < (slice+1)*live
   assign cpu_new   = rd_w.cpu + 32'd1;
   assign slice_new = rd_w.slice + 32'd1;
   assign slice_inc = {1'b0, slice_new} + 33'd1;
   assign live_eff  = (live_ff == '0) ? PW'(1) : live_ff;
   assign prod      = PRW'(slice_inc) * PRW'(live_eff);
   assign slice_end = PRW'(window_ff) < prod;

   assign key = $signed({{27{rd_w.nice[5]}}, rd_w.nice, 1'b0})
              - $signed({2'b00, tick_ff - rd_w.cpu});

   assign p_slot = rd_w.parent;
   assign wake   = ({1'b0, p_slot} < (PW+1)'(SLOTS)) && used_ff[p_slot]
                   && (state_ff[p_slot] == ptsched_pkg::SS_SLEEPING);
   assign c_slot = pword_ff.pend_slot;

   assign is_scan = (cmd.op == ptsched_pkg::OP_LIVE_SCAN) ||
                    (cmd.op == ptsched_pkg::OP_FORK_SCAN) ||
                    (cmd.op == ptsched_pkg::OP_WAIT_SCAN) ||
                    (cmd.op == ptsched_pkg::OP_SW_SCAN);

   always_comb begin
      used_in       = used_ff;
      state_in      = state_ff;
      cur_in        = cur_ff;
      tick_in       = tick_ff;
      arg_in        = arg_ff;
      live_in       = live_ff;
      cnt_in        = cnt_ff;
      ev_in         = ev_ff;
      idx_d_in      = idx_d_ff;
      ffound_in     = ffound_ff;
      fslot_in      = fslot_ff;
      zfound_in     = zfound_ff;
      zslot_in      = zslot_ff;
      zheld_in      = zheld_ff;
      rfound_in     = rfound_ff;
      rslot_in      = rslot_ff;
      par_in        = par_ff;
      was_run_in    = was_run_ff;
      pfound_in     = pfound_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      pword_in      = pword_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_sw_in     = res_sw_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_waddr     = cur_ff;
      ram_raddr     = cur_ff;
      wr_w          = rd_w;

      // shared scan pipeline: issue one slot, evaluate the previous one
      if (is_scan) begin
         ram_raddr = cnt_ff[PW-1:0];
         if (cnt_ff < CW'(SLOTS)) begin
            cnt_in   = cnt_ff + CW'(1);
            ev_in    = 1'b1;
            idx_d_in = cnt_ff[PW-1:0];
         end else begin
            ev_in = 1'b0;
         end
      end

      unique case (cmd.op)
         ptsched_pkg::OP_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = PW'(1);
            wr_w      = '0;
         end
         ptsched_pkg::OP_LOAD: begin
            arg_in        = req_argument;
            live_in       = '0;
            cnt_in        = '0;
            ev_in         = 1'b0;
            ffound_in     = 1'b0;
            zfound_in     = 1'b0;
            rfound_in     = 1'b0;
            res_status_in = ptsched_pkg::STS_OK;
            res_value_in  = '0;
            res_sw_in     = 1'b0;
         end
         ptsched_pkg::OP_LIVE_SCAN: begin
            if (ev_ff && used_ff[idx_d_ff]
                && state_ff[idx_d_ff] != ptsched_pkg::SS_ZOMBIE) begin
               live_in = live_ff + PW'(1);
            end
         end
         ptsched_pkg::OP_TICK_UPD: begin
            tick_in    = tick_ff + 32'd1;
            wr_w.cpu   = cpu_new;
            wr_w.slice = slice_end ? 32'd0 : slice_new;
            ram_we     = 1'b1;
         end
         ptsched_pkg::OP_FORK_SCAN: begin
            if (ev_ff && !ffound_ff && idx_d_ff != '0 && !used_ff[idx_d_ff]) begin
               ffound_in = 1'b1;
               fslot_in  = idx_d_ff;
            end
         end
         ptsched_pkg::OP_FORK_WR: begin
            if (ffound_ff) begin
               wr_w               = '0;
               wr_w.parent        = cur_ff;
               ram_we             = 1'b1;
               ram_waddr          = fslot_ff;
               used_in[fslot_ff]  = 1'b1;
               state_in[fslot_ff] = ptsched_pkg::SS_READY;
               res_value_in       = 32'(fslot_ff);
            end else begin
               res_status_in = ptsched_pkg::STS_FULL;
            end
         end
         ptsched_pkg::OP_EXIT_WR: begin
            wr_w.held        = arg_ff;
            ram_we           = 1'b1;
            state_in[cur_ff] = ptsched_pkg::SS_ZOMBIE;
            par_in           = p_slot;
         end
         ptsched_pkg::OP_RD_PAR: begin
            ram_raddr = par_ff;
         end
         ptsched_pkg::OP_WAKE_WR: begin
            wr_w.held        = arg_ff;
            wr_w.pend_valid  = 1'b1;
            wr_w.pend_slot   = cur_ff;
            ram_we           = 1'b1;
            ram_waddr        = par_ff;
            state_in[par_ff] = ptsched_pkg::SS_READY;
         end
         ptsched_pkg::OP_WAIT_SCAN: begin
            if (ev_ff && !zfound_ff && used_ff[idx_d_ff] && rd_w.parent == cur_ff) begin
               if (state_ff[idx_d_ff] == ptsched_pkg::SS_READY) begin
                  rfound_in = 1'b1;
                  rslot_in  = idx_d_ff;
               end else if (state_ff[idx_d_ff] == ptsched_pkg::SS_ZOMBIE) begin
                  zfound_in = 1'b1;
                  zslot_in  = idx_d_ff;
                  zheld_in  = rd_w.held;
               end
            end
         end
         ptsched_pkg::OP_WAIT_ACT: begin
            priority if (zfound_ff) begin
               res_value_in       = zheld_ff;
               used_in[zslot_ff]  = 1'b0;
               state_in[zslot_ff] = ptsched_pkg::SS_READY;
            end else if (rfound_ff) begin
               state_in[cur_ff] = ptsched_pkg::SS_SLEEPING;
               res_status_in    = ptsched_pkg::STS_SLEEPING;
            end else begin
               res_status_in = ptsched_pkg::STS_NO_CHILD;
            end
         end
         ptsched_pkg::OP_PEND_WR: begin
            wr_w.pend_valid = 1'b1;
            wr_w.pend_slot  = rslot_ff;
            ram_we          = 1'b1;
         end
         ptsched_pkg::OP_NICE_WR: begin
            priority if (arg_ff >= ptsched_pkg::NICE_HIGH)
               wr_w.nice = 6'(ptsched_pkg::NICE_HIGH);
            else if (arg_ff <= ptsched_pkg::NICE_LOW)
               wr_w.nice = 6'(ptsched_pkg::NICE_LOW);
            else
               wr_w.nice = 6'(arg_ff);
            ram_we = 1'b1;
         end
         ptsched_pkg::OP_SW_PREP: begin
            was_run_in = (state_ff[cur_ff] == ptsched_pkg::SS_RUNNING);
            if (state_ff[cur_ff] == ptsched_pkg::SS_RUNNING) begin
               state_in[cur_ff] = ptsched_pkg::SS_READY;
            end
            cnt_in    = '0;
            ev_in     = 1'b0;
            pfound_in = 1'b0;
            best_in   = {{2{thresh_ff[31]}}, thresh_ff};
         end
         ptsched_pkg::OP_SW_SCAN: begin
            if (ev_ff && used_ff[idx_d_ff] && state_ff[idx_d_ff] == ptsched_pkg::SS_READY
                && key < best_ff) begin
               best_in   = key;
               pfound_in = 1'b1;
               pick_in   = idx_d_ff;
               pword_in  = rd_w;
            end
         end
         ptsched_pkg::OP_SW_FIN: begin
            if (!pfound_ff) begin
               if (was_run_ff) state_in[cur_ff] = ptsched_pkg::SS_RUNNING;
            end else begin
               cur_in            = pick_ff;
               res_sw_in         = (pick_ff != cur_ff);
               state_in[pick_ff] = ptsched_pkg::SS_RUNNING;
               if (pword_ff.pend_valid) begin
                  wr_w            = pword_ff;
                  wr_w.pend_valid = 1'b0;
                  wr_w.pend_slot  = '0;
                  ram_we          = 1'b1;
                  ram_waddr       = pick_ff;
                  if ({1'b0, c_slot} < (PW+1)'(SLOTS) && used_ff[c_slot]
                      && state_ff[c_slot] == ptsched_pkg::SS_ZOMBIE) begin
                     used_in[c_slot]  = 1'b0;
                     state_in[c_slot] = ptsched_pkg::SS_READY;
                  end
               end
            end
         end
         ptsched_pkg::OP_DONE: begin
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            used_ff[i]  <= (i == 1);
            state_ff[i] <= (i == 1) ? ptsched_pkg::SS_RUNNING : ptsched_pkg::SS_READY;
         end
         cur_ff       <= PW'(1);
         tick_ff      <= '0;
         thresh_ff    <= '0;
         window_ff    <= ptsched_pkg::WINDOW_RESET;
         cnt_ff       <= '0;
         ev_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         tick_ff      <= tick_in;
         cnt_ff       <= cnt_in;
         ev_ff        <= ev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               ptsched_pkg::CSR_THRESHOLD: thresh_ff <= csr_data;
               ptsched_pkg::CSR_WINDOW:    window_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      arg_ff        <= arg_in;
      live_ff       <= live_in;
      idx_d_ff      <= idx_d_in;
      ffound_ff     <= ffound_in;
      fslot_ff      <= fslot_in;
      zfound_ff     <= zfound_in;
      zslot_ff      <= zslot_in;
      zheld_ff      <= zheld_in;
      rfound_ff     <= rfound_in;
      rslot_ff      <= rslot_in;
      par_ff        <= par_in;
      was_run_ff    <= was_run_in;
      pfound_ff     <= pfound_in;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      pword_ff      <= pword_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_sw_ff     <= res_sw_in;
      if (cmd.op == ptsched_pkg::OP_DONE) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_slot_ff   <= 6'(cur_ff);
         rsp_sw_ff     <= res_sw_ff;
         rsp_tick_ff   <= tick_ff;
      end
   end

   assign sts.scan_done    = (cnt_ff == CW'(SLOTS)) && !ev_ff;
   assign sts.slice_end    = slice_end;
   assign sts.wake         = wake;
   assign sts.zombie_found = zfound_ff;
   assign sts.ready_found  = rfound_ff;
   assign sts.rsp_busy     = rsp_valid_ff && !rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_running_slot = rsp_slot_ff;
   assign rsp_switched     = rsp_sw_ff;
   assign rsp_tick_total   = rsp_tick_ff;

endmodule

// File: rtl/core/process_table_scheduler.sv
// Top level of the process table scheduler: sequencer plus datapath.
// Depends on ptsched_pkg, ptsched_ctrl, ptsched_dp and ptsched_ram.
//
//   channel  direction  handshake              word
//   req      in         req_tvalid/req_tready  tdata: command, argument
//   rsp      out        rsp_tvalid/rsp_tready  tdata: status .. tick_total
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// From acceptance to rsp_tvalid: nice reads and writes the record, an unknown
// command goes straight to the response, fork scans for a free slot, tick counts
// live slots and switches when its slice ends, exit switches (waking a sleeping
// parent first), wait scans children and switches when it reaps or sleeps. Each
// scan walks the record RAM one slot a cycle. After reset S_INIT initialises slot
// one's record before req opens. A stalled rsp holds its word; the next req is
// taken meanwhile and waits at the end of its run until the output register frees.
module process_table_scheduler #(
   parameter int SLOTS = ptsched_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // command[2:0], argument[34:3], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], value[33:2], running_slot[39:34], switched[40],
   // tick_total[72:41], zero pad
   output logic [79:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   ptsched_pkg::dp_cmd_type cmd;
   ptsched_pkg::dp_sts_type sts;
   logic [1:0]              rsp_status;
   logic signed [31:0]      rsp_value;
   logic [5:0]              rsp_running_slot;
   logic                    rsp_switched;
   logic [31:0]             rsp_tick_total;

   assign csr_ready = 1'b1;

   ptsched_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_command(req_tdata[2:0]),
      .sts        (sts),
      .cmd        (cmd)
   );

   ptsched_dp #(.SLOTS(SLOTS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_argument    ($signed(req_tdata[34:3])),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_status),
      .rsp_value       (rsp_value),
      .rsp_running_slot(rsp_running_slot),
      .rsp_switched    (rsp_switched),
      .rsp_tick_total  (rsp_tick_total)
   );

   assign rsp_tdata = {7'd0, rsp_tick_total, rsp_switched, rsp_running_slot,
                       rsp_value, rsp_status};

endmodule

// File: rtl/core/ptsched_checker.sv
// Port-level checks for the process table scheduler, bound to the top.
// Depends on ptsched_pkg.
module ptsched_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_full_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ptsched_pkg::STS_FULL |-> rsp_tdata[33:2] == '0)
      else $error("table full carries a value");

   a_no_child_stays: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ptsched_pkg::STS_NO_CHILD |-> !rsp_tdata[40])
      else $error("no-child result reports a switch");

   a_sleep_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ptsched_pkg::STS_SLEEPING |-> rsp_tdata[33:2] == '0)
      else $error("sleeping result carries a value");

endmodule

bind process_table_scheduler ptsched_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
